// ===== design/mlpp_pkg.sv =====
// Shared types and constants for the monochrome LCD pixel plotter.
`timescale 1ns / 1ps
`default_nettype none

package mlpp_pkg;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [5:0] pixel_y;
        logic       color;
    } t_pix_in;

    typedef struct packed {
        logic       is_data;
        logic [7:0] out_byte;
        logic       last;
    } t_pix_out;

    localparam logic [7:0] CMD_PAGE    = 8'hB0;
    localparam logic [7:0] CMD_LINE    = 8'h40;
    localparam logic [7:0] CMD_COL_HI  = 8'h10;
    localparam logic [7:0] COL_LO_MASK = 8'h0F;
    localparam logic [7:0] BIT_ONE     = 8'h01;
    localparam logic [6:0] COL_CLAMP   = 7'd127;

endpackage : mlpp_pkg

`default_nettype wire

// ===== design/mono_lcd_pixel_plotter.sv =====
// Top level of the monochrome LCD pixel plotter: sequencer, byte unit and frame store.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (pixel_x, pixel_y, color)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (is_data, out_byte, last)
//
// A pixel is accepted in S_IDLE, which also reads the frame store; then the four command
// bytes and the data byte go out one byte per cycle while the output is not stalled,
// through the shared byte unit and the output register. After reset the frame store is
// swept to zero, all COLUMNS*PAGES entries (1024 by default); no pixel is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module mono_lcd_pixel_plotter #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire mlpp_pkg::t_pix_in i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output mlpp_pkg::t_pix_out     o_out_data
);

    import mlpp_pkg::*;

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FULL_W = ADDR_W + 4;
    localparam int COL_W  = $clog2(COLUMNS);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_CMD   = 4'b0100,
        S_DATA  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        STEP_PAGE   = 2'd0,
        STEP_LINE   = 2'd1,
        STEP_COL_HI = 2'd2,
        STEP_COL_LO = 2'd3
    } t_step;

    t_state            r_state, n_state;
    t_step             r_step, n_step;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [6:0]        r_col, n_col;
    logic [2:0]        r_page, n_page;
    logic [7:0]        r_mask, n_mask;
    logic              r_color, n_color;
    logic              r_page_ok, n_page_ok;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_out_valid, n_out_valid;
    t_pix_out          r_out_data, n_out_data;

    logic [6:0]        w_col;
    logic [2:0]        w_page;
    logic [COL_W-1:0]  w_idx_col;
    logic [FULL_W-1:0] w_idx_full;
    logic              w_accept;
    logic              w_slot_free;
    logic [7:0]        w_cmd_byte;
    logic [7:0]        w_rdata;
    logic [7:0]        w_new_byte;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic              w_re;

    assign w_col      = (i_in_data.pixel_x > {1'b0, COL_CLAMP}) ? COL_CLAMP
                                                                : i_in_data.pixel_x[6:0];
    assign w_page     = i_in_data.pixel_y[5:3];
    assign w_idx_col  = (w_col > 7'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : w_col[COL_W-1:0];
    assign w_idx_full = FULL_W'(w_page) * FULL_W'(COLUMNS) + FULL_W'(w_idx_col);

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_re        = w_accept;

    always_comb begin
        unique case (r_step)
            STEP_PAGE:   w_cmd_byte = CMD_PAGE | {5'd0, r_page};
            STEP_LINE:   w_cmd_byte = CMD_LINE | r_mask;
            STEP_COL_HI: w_cmd_byte = CMD_COL_HI | {5'd0, r_col[6:4]};
            STEP_COL_LO: w_cmd_byte = COL_LO_MASK & {1'b0, r_col};
            default:     w_cmd_byte = '0;
        endcase
    end

    assign w_new_byte = r_color ? (w_rdata | r_mask) : (w_rdata & ~r_mask);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_clr_addr  = r_clr_addr;
        n_col       = r_col;
        n_page      = r_page;
        n_mask      = r_mask;
        n_color     = r_color;
        n_page_ok   = r_page_ok;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = w_new_byte;

        unique case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_col     = w_col;
                    n_page    = w_page;
                    n_mask    = BIT_ONE << i_in_data.pixel_y[2:0];
                    n_color   = i_in_data.color;
                    n_page_ok = ({1'b0, w_page} < 4'(PAGES));
                    n_addr    = w_idx_full[ADDR_W-1:0];
                    n_step    = STEP_PAGE;
                    n_state   = S_CMD;
                end
            end
            S_CMD: begin
                if (w_slot_free) begin
                    n_out_valid         = 1'b1;
                    n_out_data.is_data  = 1'b0;
                    n_out_data.out_byte = w_cmd_byte;
                    n_out_data.last     = 1'b0;
                    unique case (r_step)
                        STEP_PAGE:   n_step = STEP_LINE;
                        STEP_LINE:   n_step = STEP_COL_HI;
                        STEP_COL_HI: n_step = STEP_COL_LO;
                        STEP_COL_LO: n_state = S_DATA;
                        default:     n_step = STEP_PAGE;
                    endcase
                end
            end
            S_DATA: begin
                if (w_slot_free) begin
                    w_we                = r_page_ok;
                    n_out_valid         = 1'b1;
                    n_out_data.is_data  = 1'b1;
                    n_out_data.out_byte = r_page_ok ? w_new_byte : 8'd0;
                    n_out_data.last     = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= STEP_PAGE;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_page     <= n_page;
        r_mask     <= n_mask;
        r_color    <= n_color;
        r_page_ok  <= n_page_ok;
        r_addr     <= n_addr;
        r_out_data <= n_out_data;
    end

    mlpp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_idx_full[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule : mono_lcd_pixel_plotter

`default_nettype wire

// ===== design/mlpp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mlpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : mlpp_ram

`default_nettype wire

// ===== design/mlpp_chk.sv =====
// Port-level checker for the monochrome LCD pixel plotter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mlpp_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire mlpp_pkg::t_pix_in  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire mlpp_pkg::t_pix_out o_out_data
);

    import mlpp_pkg::*;

    logic w_in_accept;

    assign w_in_accept = i_in_valid && !o_in_stall;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_last_on_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == o_out_data.is_data))
        else $error("last and is_data disagree");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("input taken again right after a transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input transaction changed");

endmodule : mlpp_chk

bind mono_lcd_pixel_plotter mlpp_chk u_mlpp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
